/* rtl/ffr_pkg.sv */
// ----------------------------------------------------------------------------
// ffr_pkg
// Shared types, codes and constants of the frame fragment reassembler.
// ----------------------------------------------------------------------------
package ffr_pkg;

    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned BUFFER_BYTES = 8192;
    localparam int unsigned QUEUE_DEPTH  = 4;

    localparam logic [15:0] FRAME_MAGIC   = 16'h4346;
    localparam logic [7:0]  FRAME_VERSION = 8'h01;
    localparam logic [7:0]  OP_RESET      = 8'hFE;

    localparam logic [13:0] MAX_PAYLOAD_RST   = 14'd8192;
    localparam logic [19:0] TIMEOUT_TICKS_RST = 20'd5000;

    // configuration register indexes
    localparam logic REG_MAX_PAYLOAD   = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    localparam int unsigned S_TDATA_W = 144;
    localparam int unsigned M_TDATA_W = 80;
    localparam int unsigned CFG_W     = 20;

    typedef enum logic [2:0] {
        V_HELD    = 3'd0,
        V_DONE    = 3'd1,
        V_RESET   = 3'd2,
        V_ERROR   = 3'd3,
        V_TIMEOUT = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        E_FRAME     = 2'd0,
        E_FRAGMENT  = 2'd1,
        E_TOO_LARGE = 2'd2,
        E_BUSY      = 2'd3
    } err_t;

    // outcome of the state-free header checks
    typedef enum logic [2:0] {
        CLS_TICK,
        CLS_SHORT,
        CLS_BAD_HDR,
        CLS_TOO_LARGE,
        CLS_BAD_SHAPE,
        CLS_OK
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [7:0]  op;
        logic [31:0] txn;
        logic [15:0] idx;
        logic [15:0] tot;
        logic [13:0] plen;
        logic [15:0] dlen;
        logic        dlen_gt_plen;
        logic        dlen_eq_plen;
        logic        reset_single;
    } item_t;

    // field order gives the tdata layout, verdict in the lowest bits
    typedef struct packed {
        logic        st;
        logic [12:0] off;
        logic [13:0] len;
        logic [7:0]  op;
        logic [31:0] txn;
        err_t        err;
        verdict_t    verdict;
    } res_t;

endpackage

/* rtl/ffr_front.sv */
// ----------------------------------------------------------------------------
// ffr_front
// Accepts input items and runs the checks that need no assembly state.
// ----------------------------------------------------------------------------
module ffr_front (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ffr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    input  logic [13:0]                      max_payload,
    input  logic                             q_full,
    output logic                             q_push,
    output ffr_pkg::item_t                   q_item
);

    localparam logic [16:0] BUFFER_LIMIT = 17'(ffr_pkg::BUFFER_BYTES);
    localparam logic [15:0] HDR          = 16'(ffr_pkg::HEADER_BYTES);

    logic [15:0] flen;
    logic [15:0] magic;
    logic [7:0]  version;
    logic [7:0]  op;
    logic [31:0] txn;
    logic [15:0] idx;
    logic [15:0] tot;
    logic [31:0] plen;
    logic [16:0] limit;
    logic [15:0] dlen;

    assign flen    = s_tdata[15:0];
    assign magic   = s_tdata[31:16];
    assign version = s_tdata[39:32];
    assign op      = s_tdata[47:40];
    assign txn     = s_tdata[79:48];
    assign idx     = s_tdata[95:80];
    assign tot     = s_tdata[111:96];
    assign plen    = s_tdata[143:112];

    assign limit = ({3'b000, max_payload} < BUFFER_LIMIT) ? {3'b000, max_payload}
                                                            : BUFFER_LIMIT;
    assign dlen  = flen - HDR;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item              = '0;
        q_item.op           = op;
        q_item.txn          = txn;
        q_item.idx          = idx;
        q_item.tot          = tot;
        q_item.plen         = plen[13:0];
        q_item.dlen         = dlen;
        q_item.dlen_gt_plen = {16'h0000, dlen} > plen;
        q_item.dlen_eq_plen = {16'h0000, dlen} == plen;
        q_item.reset_single = (op == ffr_pkg::OP_RESET) && (tot == 16'd1) && (idx == 16'd0);
        if (s_tuser) begin
            q_item.cls = ffr_pkg::CLS_TICK;
        end else if (flen < HDR) begin
            q_item.cls = ffr_pkg::CLS_SHORT;
        end else if (magic != ffr_pkg::FRAME_MAGIC || version != ffr_pkg::FRAME_VERSION) begin
            q_item.cls = ffr_pkg::CLS_BAD_HDR;
        end else if (plen > {15'h0000, limit}) begin
            q_item.cls = ffr_pkg::CLS_TOO_LARGE;
        end else if (tot == 16'd0 || idx >= tot) begin
            q_item.cls = ffr_pkg::CLS_BAD_SHAPE;
        end else begin
            q_item.cls = ffr_pkg::CLS_OK;
        end
    end

endmodule

/* rtl/ffr_queue.sv */
// ----------------------------------------------------------------------------
// ffr_queue
// Short register queue between the classifying front and the assembly back.
// ----------------------------------------------------------------------------
module ffr_queue #(
    parameter int unsigned DEPTH = ffr_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ffr_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output ffr_pkg::item_t head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ffr_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full   = (count_reg == FULL_CNT);
    assign valid  = (count_reg != '0);
    assign head   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/ffr_back.sv */
// ----------------------------------------------------------------------------
// ffr_back
// Assembly state machine: applies classified items and registers the result.
// ----------------------------------------------------------------------------
module ffr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [19:0]                   timeout_ticks,
    input  logic                          q_valid,
    input  ffr_pkg::item_t                q_head,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ffr_pkg::M_TDATA_W-1:0] m_tdata
);

    typedef enum logic {
        ST_IDLE,
        ST_ASSEMBLING
    } state_t;

    state_t       state_reg, state_next;
    logic [7:0]   held_op_reg, held_op_next;
    logic [31:0]  held_txn_reg, held_txn_next;
    logic [13:0]  held_plen_reg, held_plen_next;
    logic [15:0]  held_tot_reg, held_tot_next;
    logic [15:0]  seen_reg, seen_next;
    logic [13:0]  assembled_reg, assembled_next;
    logic [19:0]  ticks_reg, ticks_next;
    logic         m_valid_reg, m_valid_next;
    ffr_pkg::res_t res_reg, res_next;

    ffr_pkg::res_t res;
    logic         clear;
    logic [19:0]  start_ticks;
    logic [13:0]  room;
    logic [13:0]  sum;
    logic [15:0]  seen_inc;

    assign start_ticks = (timeout_ticks == 20'd0) ? 20'd1 : timeout_ticks;
    assign room        = held_plen_reg - assembled_reg;
    assign sum         = assembled_reg + q_head.dlen[13:0];
    assign seen_inc    = seen_reg + 16'd1;
    assign q_pop       = q_valid && (!m_valid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        held_op_next   = held_op_reg;
        held_txn_next  = held_txn_reg;
        held_plen_next = held_plen_reg;
        held_tot_next  = held_tot_reg;
        seen_next      = seen_reg;
        assembled_next = assembled_reg;
        ticks_next     = ticks_reg;
        clear          = 1'b0;
        res            = '0;
        res.verdict    = ffr_pkg::V_HELD;
        res.err        = ffr_pkg::E_FRAME;

        if (q_pop) begin
            case (q_head.cls)
                ffr_pkg::CLS_TICK: begin
                    if (state_reg == ST_ASSEMBLING) begin
                        if (ticks_reg <= 20'd1) begin
                            clear       = 1'b1;
                            res.verdict = ffr_pkg::V_TIMEOUT;
                            res.txn     = held_txn_reg;
                        end else begin
                            ticks_next = ticks_reg - 20'd1;
                        end
                    end
                end
                ffr_pkg::CLS_SHORT: begin
                    res.verdict = ffr_pkg::V_ERROR;
                end
                ffr_pkg::CLS_BAD_HDR: begin
                    res.verdict = ffr_pkg::V_ERROR;
                    res.txn     = q_head.txn;
                end
                ffr_pkg::CLS_TOO_LARGE: begin
                    res.verdict = ffr_pkg::V_ERROR;
                    res.err     = ffr_pkg::E_TOO_LARGE;
                    res.txn     = q_head.txn;
                end
                ffr_pkg::CLS_BAD_SHAPE: begin
                    res.verdict = ffr_pkg::V_ERROR;
                    res.err     = ffr_pkg::E_FRAGMENT;
                    res.txn     = q_head.txn;
                end
                ffr_pkg::CLS_OK: begin
                    res.txn = q_head.txn;
                    if (state_reg == ST_IDLE) begin
                        if (q_head.idx != 16'd0 || q_head.dlen_gt_plen) begin
                            res.verdict = ffr_pkg::V_ERROR;
                            res.err     = ffr_pkg::E_FRAGMENT;
                        end else if (q_head.tot == 16'd1) begin
                            if (!q_head.dlen_eq_plen) begin
                                res.verdict = ffr_pkg::V_ERROR;
                                res.err     = ffr_pkg::E_FRAGMENT;
                            end else if (q_head.op == ffr_pkg::OP_RESET) begin
                                res.verdict = ffr_pkg::V_RESET;
                            end else begin
                                res.verdict = ffr_pkg::V_DONE;
                                res.op      = q_head.op;
                                res.len     = q_head.plen;
                                res.st      = 1'b1;
                            end
                        end else begin
                            // first fragment: open the assembly
                            state_next     = ST_ASSEMBLING;
                            held_op_next   = q_head.op;
                            held_txn_next  = q_head.txn;
                            held_plen_next = q_head.plen;
                            held_tot_next  = q_head.tot;
                            seen_next      = 16'd1;
                            assembled_next = q_head.dlen[13:0];
                            ticks_next     = start_ticks;
                            res.st         = 1'b1;
                        end
                    end else if (q_head.reset_single) begin
                        clear       = 1'b1;
                        res.verdict = ffr_pkg::V_RESET;
                    end else if (q_head.txn != held_txn_reg) begin
                        res.verdict = ffr_pkg::V_ERROR;
                        res.err     = ffr_pkg::E_BUSY;
                    end else if (q_head.plen != held_plen_reg || q_head.tot != held_tot_reg ||
                                 q_head.idx != seen_reg ||
                                 q_head.dlen > {2'b00, room}) begin
                        clear       = 1'b1;
                        res.verdict = ffr_pkg::V_ERROR;
                        res.err     = ffr_pkg::E_FRAGMENT;
                        res.txn     = held_txn_reg;
                    end else if (seen_inc == held_tot_reg) begin
                        // last fragment: close out
                        clear   = 1'b1;
                        res.txn = held_txn_reg;
                        if (sum == held_plen_reg) begin
                            res.verdict = ffr_pkg::V_DONE;
                            res.op      = held_op_reg;
                            res.len     = sum;
                            res.off     = assembled_reg[12:0];
                            res.st      = 1'b1;
                        end else begin
                            res.verdict = ffr_pkg::V_ERROR;
                            res.err     = ffr_pkg::E_FRAGMENT;
                        end
                    end else begin
                        seen_next      = seen_inc;
                        assembled_next = sum;
                        ticks_next     = start_ticks;
                        res.off        = assembled_reg[12:0];
                        res.st         = 1'b1;
                    end
                end
                default: begin
                    res.verdict = ffr_pkg::V_HELD;
                end
            endcase
        end

        if (clear) begin
            state_next     = ST_IDLE;
            held_op_next   = '0;
            held_txn_next  = '0;
            held_plen_next = '0;
            held_tot_next  = '0;
            seen_next      = '0;
            assembled_next = '0;
            ticks_next     = '0;
        end

        if (q_pop) begin
            m_valid_next = 1'b1;
            res_next     = res;
        end else begin
            m_valid_next = m_valid_reg && !m_tready;
            res_next     = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            held_op_reg   <= '0;
            held_txn_reg  <= '0;
            held_plen_reg <= '0;
            held_tot_reg  <= '0;
            seen_reg      <= '0;
            assembled_reg <= '0;
            ticks_reg     <= '0;
            m_valid_reg   <= 1'b0;
            res_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            held_op_reg   <= held_op_next;
            held_txn_reg  <= held_txn_next;
            held_plen_reg <= held_plen_next;
            held_tot_reg  <= held_tot_next;
            seen_reg      <= seen_next;
            assembled_reg <= assembled_next;
            ticks_reg     <= ticks_next;
            m_valid_reg   <= m_valid_next;
            res_reg       <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ffr_pkg::M_TDATA_W - $bits(ffr_pkg::res_t)){1'b0}}, res_reg};

endmodule

/* rtl/frame_fragment_reassembler.sv */
// ----------------------------------------------------------------------------
// frame_fragment_reassembler
// Checks frame descriptors and reassembles fragmented transactions.
// ----------------------------------------------------------------------------
//  channel   direction  width        contents
//  s_        in         144 + 1      frame descriptor or time tick
//  m_        out        80           verdict, error, transaction, store offset
//  cfg_      in         1 + 20       max_payload, timeout_ticks
//
//  One item per cycle sustained while m_tready stays high; each item gives
//  one result item. An accepted item is written into the queue; the back
//  pops it and registers its result, which drives m_tvalid.
//  The front takes items while the queue has room; the back drains it
//  whenever the output register is empty or being taken.
//  aresetn clears the queue, the assembly state and the output register.
// ----------------------------------------------------------------------------
module frame_fragment_reassembler #(
    parameter int unsigned QUEUE_DEPTH = ffr_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // frame_length, magic, version, op_code, txn_id,
    // frag_num, frag_count, payload_bytes
    input  logic [ffr_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // verdict, error_code, reply_transaction, done_op, done_length,
    // store_offset, store_enable, zero fill
    output logic [ffr_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ffr_pkg::CFG_W-1:0]     cfg_wdata
);

    logic [13:0]    max_payload_reg;
    logic [19:0]    timeout_ticks_reg;
    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    ffr_pkg::item_t q_item;
    ffr_pkg::item_t q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg   <= ffr_pkg::MAX_PAYLOAD_RST;
            timeout_ticks_reg <= ffr_pkg::TIMEOUT_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                ffr_pkg::REG_MAX_PAYLOAD:   max_payload_reg   <= cfg_wdata[13:0];
                ffr_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata[19:0];
                default: begin
                    max_payload_reg <= max_payload_reg;
                end
            endcase
        end
    end

    ffr_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .max_payload (max_payload_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_item)
    );

    ffr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    ffr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .timeout_ticks (timeout_ticks_reg),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

/* rtl/ffr_checker.sv */
// ----------------------------------------------------------------------------
// ffr_checker
// Port-level checks on the result channel of the reassembler.
// ----------------------------------------------------------------------------
module ffr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ffr_pkg::M_TDATA_W-1:0] m_tdata
);

    // no result item right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'd4)
        else $error("verdict out of range");

    // error code only with an error verdict, done fields only with completion
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:3] == 2'd0 || m_tdata[2:0] == 3'd3) &&
                     (m_tdata[58:37] == 22'd0 || m_tdata[2:0] == 3'd1))
        else $error("fields set for wrong verdict");

    a_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[72] |-> m_tdata[71:59] == 13'd0 &&
                                      (m_tdata[2:0] != 3'd1))
        else $error("store offset without store enable");

endmodule

bind frame_fragment_reassembler ffr_checker u_ffr_checker (.*);

/* tb/sv/frame_reply_checker.sv */
// ----------------------------------------------------------------------------
// frame_reply_checker
// Watches the descriptor, reply and register ports of the frame fragment
// reassembler, keeps its own copy of the assembly state and the registers,
// works out the reply each accepted item must give, and compares every
// accepted reply field by field with the oldest reply still due.
// ----------------------------------------------------------------------------
module frame_reply_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // frame_length, magic, version, op_code, txn_id,
    // frag_num, frag_count, payload_bytes
    input  logic [ffr_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // verdict, error_code, reply_transaction, done_op, done_length,
    // store_offset, store_enable, zero fill
    input  logic [ffr_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ffr_pkg::CFG_W-1:0]     cfg_wdata,
    output int                            mismatches,
    output int                            replies_waiting,
    output int                            replies_checked,
    output int                            completes_seen,
    output int                            drops_seen
);
    import ffr_pkg::*;

    typedef struct packed {
        logic [31:0] plen;
        logic [15:0] tot;
        logic [15:0] idx;
        logic [31:0] txn;
        logic [7:0]  op;
        logic [7:0]  ver;
        logic [15:0] magic;
        logic [15:0] flen;
    } frame_t;

    logic [13:0] max_payload   = MAX_PAYLOAD_RST;
    logic [19:0] timeout_ticks = TIMEOUT_TICKS_RST;

    logic        assembling = 1'b0;
    logic [7:0]  held_op    = '0;
    logic [31:0] held_txn   = '0;
    logic [13:0] held_plen  = '0;
    logic [15:0] held_tot   = '0;
    logic [15:0] frags_seen = '0;
    logic [13:0] assembled  = '0;
    logic [19:0] ticks_left = '0;

    res_t replies_due[$];
    int   n_bad     = 0;
    int   n_checked = 0;
    int   n_done    = 0;
    int   n_drops   = 0;

    initial begin
        mismatches      = 0;
        replies_waiting = 0;
        replies_checked = 0;
        completes_seen  = 0;
        drops_seen      = 0;
    end

    function automatic void drop_assembly();
        assembling = 1'b0;
        held_op    = '0;
        held_txn   = '0;
        held_plen  = '0;
        held_tot   = '0;
        frags_seen = '0;
        assembled  = '0;
        ticks_left = '0;
    endfunction

    function automatic logic [19:0] fresh_ticks();
        return (timeout_ticks == 0) ? 20'd1 : timeout_ticks;
    endfunction

    // advance the assembly state by one item and return the reply it gives
    function automatic res_t reply_for_item(input logic is_tick, input frame_t f);
        res_t        r;
        int unsigned limit;
        int unsigned dlen;
        int unsigned pos;
        r = '0;
        if (is_tick) begin
            if (assembling) begin
                if (ticks_left <= 1) begin
                    r.verdict = V_TIMEOUT;
                    r.txn     = held_txn;
                    drop_assembly();
                end else begin
                    ticks_left = ticks_left - 20'd1;
                end
            end
            return r;
        end
        r.verdict = V_ERROR;
        if (f.flen < HEADER_BYTES)
            return r;
        r.txn = f.txn;
        if (f.magic != FRAME_MAGIC || f.ver != FRAME_VERSION)
            return r;
        limit = (max_payload < BUFFER_BYTES) ? max_payload : BUFFER_BYTES;
        r.err = E_TOO_LARGE;
        if (f.plen > limit)
            return r;
        r.err = E_FRAGMENT;
        if (f.tot == 0 || f.idx >= f.tot)
            return r;
        dlen = f.flen - HEADER_BYTES;

        if (!assembling) begin
            if (f.idx != 0 || dlen > f.plen)
                return r;
            if (f.tot == 1) begin
                if (dlen != f.plen)
                    return r;
                r.err = E_FRAME;
                if (f.op == OP_RESET) begin
                    r.verdict = V_RESET;
                end else begin
                    r.verdict = V_DONE;
                    r.op      = f.op;
                    r.len     = f.plen[13:0];
                    r.st      = 1'b1;
                end
                return r;
            end
            assembling = 1'b1;
            held_op    = f.op;
            held_txn   = f.txn;
            held_plen  = f.plen[13:0];
            held_tot   = f.tot;
            frags_seen = 16'd1;
            assembled  = dlen[13:0];
            ticks_left = fresh_ticks();
            r.verdict  = V_HELD;
            r.err      = E_FRAME;
            r.st       = 1'b1;
            return r;
        end

        // a single-fragment reset aborts whatever is held
        if (f.op == OP_RESET && f.tot == 1 && f.idx == 0) begin
            drop_assembly();
            r.verdict = V_RESET;
            r.err     = E_FRAME;
            return r;
        end
        if (f.txn != held_txn) begin
            r.err = E_BUSY;
            return r;
        end
        if (f.plen != held_plen || f.tot != held_tot || f.idx != frags_seen ||
            dlen > int'(held_plen) - int'(assembled)) begin
            drop_assembly();
            return r;
        end

        pos        = 32'(assembled);
        assembled  = assembled + dlen[13:0];
        frags_seen = frags_seen + 16'd1;
        if (frags_seen == held_tot) begin
            if (assembled == held_plen) begin
                r.verdict = V_DONE;
                r.err     = E_FRAME;
                r.op      = held_op;
                r.len     = assembled;
                r.off     = pos[12:0];
                r.st      = 1'b1;
            end
            drop_assembly();
            return r;
        end
        ticks_left = fresh_ticks();
        r.verdict  = V_HELD;
        r.err      = E_FRAME;
        r.off      = pos[12:0];
        r.st       = 1'b1;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (n_bad < 10)
                $display("reply %0d: %s expected %h, got %h", n_checked, name, want, got);
            n_bad++;
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (!aresetn) begin
            max_payload   = MAX_PAYLOAD_RST;
            timeout_ticks = TIMEOUT_TICKS_RST;
            drop_assembly();
            replies_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MAX_PAYLOAD:   max_payload   = cfg_wdata[13:0];
                    REG_TIMEOUT_TICKS: timeout_ticks = cfg_wdata[19:0];
                endcase
            end
            // older reply first, so one arriving with nothing due is caught
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    if (n_bad < 10)
                        $display("reply with nothing due: %h", m_tdata);
                    n_bad++;
                end else begin
                    want = replies_due.pop_front();
                    got  = m_tdata[$bits(res_t)-1:0];
                    check_field("verdict", 32'(want.verdict), 32'(got.verdict));
                    check_field("error_code", 32'(want.err), 32'(got.err));
                    check_field("reply_transaction", want.txn, got.txn);
                    check_field("done_op", 32'(want.op), 32'(got.op));
                    check_field("done_length", 32'(want.len), 32'(got.len));
                    check_field("store_offset", 32'(want.off), 32'(got.off));
                    check_field("store_enable", 32'(want.st), 32'(got.st));
                    check_field("fill", '0, 32'(m_tdata[M_TDATA_W-1:$bits(res_t)]));
                    if (want.verdict == V_DONE)
                        n_done++;
                    if (want.verdict == V_TIMEOUT)
                        n_drops++;
                    n_checked++;
                end
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(reply_for_item(s_tuser, s_tdata));
        end
        mismatches      <= n_bad;
        replies_waiting <= replies_due.size();
        replies_checked <= n_checked;
        completes_seen  <= n_done;
        drops_seen      <= n_drops;
    end

endmodule

/* tb/sv/frame_fragment_reassembler_tb.sv */
// ----------------------------------------------------------------------------
// frame_fragment_reassembler_tb
// Drives frame descriptors and time ticks into the reassembler under several
// register settings: a directed pass over every frame check and most assembly
// cases, then random transactions split into fragments with ticks, busy
// frames, aborts and broken fragments mixed in. Both sides idle at random.
// ----------------------------------------------------------------------------
module frame_fragment_reassembler_tb;
    import ffr_pkg::*;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = REG_MAX_PAYLOAD;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int mismatches;
    int replies_waiting;
    int replies_checked;
    int completes_seen;
    int drops_seen;

    int          frames_sent   = 0;
    int          ticks_sent    = 0;
    int          settings_used = 1;
    int unsigned cur_limit     = BUFFER_BYTES;
    bit          gaps_on       = 1'b1;
    bit          stalls_on     = 1'b1;
    bit          long_hold     = 1'b0;

    frame_fragment_reassembler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    frame_reply_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .replies_waiting (replies_waiting),
        .replies_checked (replies_checked),
        .completes_seen  (completes_seen),
        .drops_seen      (drops_seen)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d replies still due", replies_waiting);
        $display("simulation failed");
        $finish;
    end

    // receiver: random stall before each reply, one long hold on request
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (long_hold) begin
                stall     = 80;
                long_hold = 1'b0;
            end else begin
                stall = stalls_on ? $urandom_range(0, 9) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // hold valid through back-to-back items, drop it only for a gap
    task automatic push_item(input logic is_tick, input logic [S_TDATA_W-1:0] bits);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_tick;
        s_tdata  <= bits;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (is_tick)
            ticks_sent++;
        else
            frames_sent++;
    endtask

    task automatic send_frame(input logic [15:0] flen, input logic [15:0] magic,
                              input logic [7:0] ver, input logic [7:0] op,
                              input logic [31:0] txn, input logic [15:0] idx,
                              input logic [15:0] tot, input logic [31:0] plen);
        push_item(1'b0, {plen, tot, idx, txn, op, ver, magic, flen});
    endtask

    task automatic send_fragment(input logic [7:0] op, input logic [31:0] txn,
                                 input int idx, input int tot,
                                 input int unsigned plen, input int dlen);
        send_frame(16'(HEADER_BYTES + dlen), FRAME_MAGIC, FRAME_VERSION, op, txn,
                   16'(idx), 16'(tot), plen);
    endtask

    // tick items carry random data that the block must ignore
    task automatic send_tick();
        push_item(1'b1, {$urandom(), $urandom(), $urandom(), $urandom(), 16'($urandom())});
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_waiting != 0) @(posedge aclk);
        repeat (QUEUE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] mp, input logic [CFG_W-1:0] ticks);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_PAYLOAD;
        cfg_wdata <= mp;
        @(posedge aclk);
        cfg_index <= REG_TIMEOUT_TICKS;
        cfg_wdata <= ticks;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_limit = (mp[13:0] < BUFFER_BYTES) ? mp[13:0] : BUFFER_BYTES;
        settings_used++;
    endtask

    // send about n items, frames and ticks together
    task automatic run_random(input int n);
        int          stop;
        int          kind;
        int          tot;
        int          k;
        int          d;
        int          fault;
        int          cap;
        int unsigned plen;
        int unsigned remaining;
        logic [31:0] txn;
        logic [7:0]  op;
        bit          broken;
        stop = frames_sent + ticks_sent + n;
        while (frames_sent + ticks_sent < stop) begin
            if ($urandom_range(0, 29) == 0) begin
                gaps_on   = $urandom_range(0, 3) != 0;
                stalls_on = $urandom_range(0, 3) != 0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // well-formed transaction with occasional disturbances
                txn = $urandom();
                op  = ($urandom_range(0, 7) == 0) ? OP_RESET : 8'($urandom());
                k   = $urandom_range(0, 19);
                tot = (k < 4) ? 1 : (k < 17) ? $urandom_range(2, 6) : $urandom_range(7, 40);
                cap = (cur_limit < 400) ? cur_limit : 400;
                plen = ($urandom_range(0, 9) == 0) ? cur_limit : $urandom_range(0, cap);
                remaining = plen;
                broken    = 1'b0;
                k         = 0;
                while (k < tot && !broken) begin
                    d = (k == tot - 1) ? remaining
                                       : $urandom_range(0, 2 * remaining / (tot - k));
                    if (d > remaining)
                        d = remaining;
                    fault = $urandom_range(0, 99);
                    if (fault < 8) begin
                        send_tick();
                    end else if (fault < 10) begin
                        send_fragment(8'($urandom()), $urandom(), 0, $urandom_range(1, 4), 0, 0);
                    end else if (fault == 10) begin
                        send_fragment(OP_RESET, $urandom(), 0, 1, 0, 0);
                        broken = 1'b1;
                    end else if (fault == 11) begin
                        // lose this fragment, the next one arrives out of order
                        k++;
                        continue;
                    end else if (fault < 14) begin
                        case ($urandom_range(0, 4))
                            0: send_fragment(op, txn, k + 1, tot, plen, d);
                            1: send_fragment(op, txn, k, tot + 1, plen, d);
                            2: send_fragment(op, txn, k, tot, plen + 1, d);
                            3: send_fragment(op, txn, k, tot, plen,
                                             remaining + 1 + $urandom_range(0, 50));
                            default: send_fragment(op, txn, tot - 1, tot, plen,
                                                   (remaining > 0) ? remaining - 1 : 0);
                        endcase
                        broken = 1'b1;
                    end
                    if (!broken) begin
                        send_fragment(op, txn, k, tot, plen, d);
                        remaining = remaining - d;
                        k++;
                    end
                end
            end else if (kind < 75) begin
                if ($urandom_range(0, 1) == 0)
                    send_frame(16'($urandom()), 16'($urandom()), 8'($urandom()),
                               8'($urandom()), $urandom(), 16'($urandom()),
                               16'($urandom()), $urandom());
                else
                    send_frame(16'($urandom_range(0, 300)), FRAME_MAGIC, FRAME_VERSION,
                               ($urandom_range(0, 3) == 0) ? OP_RESET : 8'($urandom()),
                               $urandom(), 16'($urandom_range(0, 3)),
                               16'($urandom_range(0, 3)),
                               $urandom_range(0, cur_limit + 2));
            end else if (kind < 88) begin
                repeat ($urandom_range(1, 8)) send_tick();
            end else begin
                case ($urandom_range(0, 2))
                    0: send_frame(16'($urandom_range(0, HEADER_BYTES - 1)), FRAME_MAGIC,
                                  FRAME_VERSION, 8'($urandom()), $urandom(), 0, 1, 0);
                    1: send_frame(HEADER_BYTES, FRAME_MAGIC ^ (16'd1 << $urandom_range(0, 15)),
                                  FRAME_VERSION ^ 8'($urandom_range(0, 1) << $urandom_range(0, 7)),
                                  8'($urandom()), $urandom(), 0, 1, 0);
                    default: send_frame(HEADER_BYTES, FRAME_MAGIC, FRAME_VERSION,
                                        8'($urandom()), $urandom(), 0, 1,
                                        ($urandom_range(0, 3) == 0) ? $urandom() | 32'h8000_0000
                                            : cur_limit + 1 + $urandom_range(0, 1000));
                endcase
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pass at the reset register values
        send_tick();
        send_frame(15, FRAME_MAGIC, FRAME_VERSION, 8'h10, 32'h1111_0001, 0, 1, 0);
        send_frame(16, 16'h4347, FRAME_VERSION, 8'h10, 32'h1111_0002, 0, 1, 0);
        send_frame(16, FRAME_MAGIC, 8'h02, 8'h10, 32'h1111_0003, 0, 1, 0);
        send_frame(16, FRAME_MAGIC, FRAME_VERSION, 8'h10, 32'h1111_0004, 0, 1, 8193);
        send_frame(16, FRAME_MAGIC, FRAME_VERSION, 8'h10, 32'h1111_0005, 0, 0, 0);
        send_fragment(8'h10, 32'h1111_0006, 3, 3, 0, 0);
        send_fragment(8'h10, 32'h1111_0007, 1, 3, 8, 2);
        send_fragment(8'h10, 32'h1111_0008, 0, 2, 4, 5);
        send_fragment(8'h10, 32'h1111_0009, 0, 1, 6, 5);
        send_fragment(OP_RESET, 32'h1111_000A, 0, 1, 0, 0);
        send_fragment(8'h21, 32'h1111_000B, 0, 1, 4, 4);
        send_fragment(8'h22, 32'h1111_000C, 0, 1, 0, 0);
        // full buffer, then an empty last fragment whose offset wraps
        send_fragment(8'hFF, 32'hFFFF_FFFF, 0, 2, BUFFER_BYTES, BUFFER_BYTES);
        send_fragment(8'hFF, 32'hFFFF_FFFF, 1, 2, BUFFER_BYTES, 0);
        // busy, then a reset that aborts without length checks
        send_fragment(8'h30, 32'h20, 0, 3, 10, 4);
        send_tick();
        send_fragment(8'h31, 32'h21, 0, 2, 0, 0);
        send_fragment(OP_RESET, 32'h22, 0, 1, 5, 24);
        send_fragment(8'h40, 32'h30, 0, 3, 9, 3);
        send_fragment(8'h40, 32'h30, 2, 3, 9, 3);
        send_fragment(8'h50, 32'h40, 0, 2, 6, 2);
        send_fragment(8'h50, 32'h40, 1, 2, 6, 2);
        send_fragment(8'h60, 32'h50, 0, 3, 8, 2);
        send_fragment(8'h60, 32'h50, 1, 3, 8, 7);
        send_fragment(8'h70, 32'h60, 0, 2, 8, 8);
        send_fragment(8'h70, 32'h60, 1, 2, 7, 0);

        run_random(300);
        set_config(0, 0);
        run_random(200);
        set_config(20'h3FFF, 3);
        // fill the block against a stalled receiver
        gaps_on   = 1'b0;
        long_hold = 1'b1;
        run_random(40);
        gaps_on = 1'b1;
        run_random(260);
        set_config(100, 20'hFFFFF);
        run_random(250);
        set_config(1500, 2);
        run_random(250);
        set_config(8191, 1);
        run_random(200);
        settle();

        $display("sent %0d frames and %0d ticks under %0d register settings",
                 frames_sent, ticks_sent, settings_used);
        $display("checked %0d replies: %0d transactions completed, %0d assemblies timed out",
                 replies_checked, completes_seen, drops_seen);
        if (mismatches == 0 && replies_waiting == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* frame_fragment_reassembler.f */
rtl/ffr_pkg.sv
rtl/ffr_front.sv
rtl/ffr_queue.sv
rtl/ffr_back.sv
rtl/frame_fragment_reassembler.sv
rtl/ffr_checker.sv
tb/sv/frame_reply_checker.sv
tb/sv/frame_fragment_reassembler_tb.sv
